// ===== rtl/lpfd_pkg.sv =====
// lpfd_pkg: shared types and constants for the length-prefixed frame deframer
// holds result kinds, config register indexes, config and result structs
// no dependencies
package lpfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgLenW = 12;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LenW-1:0] LengthLimit = 16'd2048;

  localparam logic [CfgLenW-1:0] MinLengthRst = 12'd20;
  localparam logic [CfgLenW-1:0] MaxLengthRst = 12'd1500;
  localparam logic [ByteW-1:0]   DelimRst     = 8'd0;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindAccept  = 2'd1,
    KindDrop    = 2'd2,
    KindReject  = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelim  = 2'd0,
    CfgMinLen = 2'd1,
    CfgMaxLen = 2'd2,
    CfgUnused = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]   delim;
    logic [CfgLenW-1:0] min_len;
    logic [CfgLenW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]       out_byte;
    kind_e                  kind;
    logic signed [LenW-1:0] frame_length;
  } res_t;

endpackage

// ===== rtl/lpfd_cfg.sv =====
// lpfd_cfg: configuration registers of the deframer
// plain write port, no read-back; depends on lpfd_pkg
module lpfd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpfd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [lpfd_pkg::CfgLenW-1:0]    cfg_wdata_i,
  output lpfd_pkg::cfg_t                  cfg_o
);
  import lpfd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgDelim:  cfg_d.delim   = cfg_wdata_i[ByteW-1:0];
        CfgMinLen: cfg_d.min_len = cfg_wdata_i;
        CfgMaxLen: cfg_d.max_len = cfg_wdata_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim   <= DelimRst;
      cfg_q.min_len <= MinLengthRst;
      cfg_q.max_len <= MaxLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lpfd_in_reg.sv =====
// lpfd_in_reg: input register stage holding one accepted byte
// stalls the sender while the held byte cannot advance; depends on lpfd_pkg
module lpfd_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lpfd_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                        advance_i,
  output logic                        hold_valid_o,
  output logic [lpfd_pkg::ByteW-1:0]  hold_byte_o
);
  import lpfd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_byte_o  = byte_q;

endmodule

// ===== rtl/lpfd_core.sv =====
// lpfd_core: framing state and per-byte result logic
// updates state once per advancing byte; depends on lpfd_pkg
module lpfd_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpfd_pkg::cfg_t              cfg_i,
  input  logic [lpfd_pkg::ByteW-1:0]  byte_i,
  input  logic                        step_i,
  output logic                        res_valid_o,
  output lpfd_pkg::res_t              res_o
);
  import lpfd_pkg::*;

  localparam logic [2:0] PhLenLo   = 3'd0;
  localparam logic [2:0] PhLenHi   = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhTrailer = 3'd3;
  localparam logic [2:0] PhHunt    = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [ByteW-1:0]   first_q, first_d;
  logic [LenW-1:0]    cur_len_q, cur_len_d;
  logic [CfgLenW-1:0] count_q, count_d;

  logic [LenW-1:0] raw;
  logic [LenW-1:0] hi_lim;
  logic            reject;

  assign raw    = {byte_i, first_q};
  assign hi_lim = ({4'd0, cfg_i.max_len} > LengthLimit) ? LengthLimit
                                                        : {4'd0, cfg_i.max_len};
  assign reject = raw[LenW-1] || (raw < {4'd0, cfg_i.min_len}) || (raw > hi_lim);

  always_comb begin
    phase_d            = phase_q;
    first_d            = first_q;
    cur_len_d          = cur_len_q;
    count_d            = count_q;
    res_valid_o        = 1'b0;
    res_o.out_byte     = '0;
    res_o.kind         = KindPayload;
    res_o.frame_length = '0;
    case (phase_q)
      PhLenLo: begin
        first_d = byte_i;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        cur_len_d = raw;
        count_d   = '0;
        if (reject) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KindReject;
          res_o.frame_length = raw;
          if (first_q == cfg_i.delim) begin
            first_d = byte_i;
            phase_d = PhLenHi;
          end else if (byte_i == cfg_i.delim) begin
            phase_d = PhLenLo;
          end else begin
            phase_d = PhHunt;
          end
        end else begin
          phase_d = (raw == '0) ? PhTrailer : PhPayload;
        end
      end
      PhPayload: begin
        res_valid_o    = 1'b1;
        res_o.out_byte = byte_i;
        count_d        = count_q + 1'b1;
        if ({4'd0, count_d} >= cur_len_q) begin
          phase_d = PhTrailer;
        end
      end
      PhTrailer: begin
        res_valid_o        = 1'b1;
        res_o.frame_length = cur_len_q;
        if (byte_i == cfg_i.delim) begin
          res_o.kind = KindAccept;
          phase_d    = PhLenLo;
        end else begin
          res_o.kind = KindDrop;
          phase_d    = PhHunt;
        end
      end
      default: begin
        phase_d = (byte_i == cfg_i.delim) ? PhLenLo : PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLenLo;
      first_q   <= '0;
      cur_len_q <= '0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      cur_len_q <= cur_len_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// length_prefixed_frame_deframer: top level of the frame deframer
// instantiates lpfd_cfg, lpfd_in_reg and lpfd_core, holds the result register
// depends on lpfd_pkg
//
// Usage:
//   Received bytes enter on rx_byte_i with in_valid_i / in_stall_o; a
//   transaction happens when valid is high and stall is low. Each frame is
//   a little-endian signed 16-bit length, that many payload bytes and one
//   delimiter byte. Results leave on out_byte_o, kind_o and frame_length_o
//   with out_valid_o / out_stall_i: one per payload byte, one on the trailer
//   and one on a rejected length; length bytes and hunted bytes give none.
//   Throughput is one byte per cycle while the receiver does not stall. A
//   taken byte sits in the input register while the framing logic works
//   on it, and its result is loaded into the result register when the
//   byte advances. While the receiver stalls, the result register holds
//   and one more byte may wait in the input register; bytes that give no
//   result still pass. Reset sets the delimiter to 0, the length window to
//   20..1500 and the framer to expect a first length byte.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block idles.
module length_prefixed_frame_deframer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpfd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lpfd_pkg::CfgLenW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [lpfd_pkg::ByteW-1:0]         rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lpfd_pkg::ByteW-1:0]         out_byte_o,
  output logic [1:0]                         kind_o,
  output logic signed [lpfd_pkg::LenW-1:0]   frame_length_o
);
  import lpfd_pkg::*;

  cfg_t             cfg;
  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             res_valid;
  res_t             res;
  logic             advance;
  logic             out_free;
  logic             res_load;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  lpfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lpfd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (advance),
    .hold_valid_o (hold_valid),
    .hold_byte_o  (hold_byte)
  );

  lpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .byte_i      (hold_byte),
    .step_i      (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = hold_valid && (!res_valid || out_free);
  assign res_load = advance && res_valid;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q.out_byte;
  assign kind_o         = out_q.kind;
  assign frame_length_o = out_q.frame_length;

  a_stall_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> hold_valid)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && hold_valid && res_valid) |-> !advance && in_stall_o)
    else $error("result would overwrite a stalled result");

  a_payload_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res.kind == KindPayload) |=> (frame_length_o == '0))
    else $error("payload result carries a nonzero length");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res.kind != KindPayload) |=> (out_valid_o && out_byte_o == '0))
    else $error("status result carries a nonzero byte");

endmodule

// ===== sim/lpfd_checker.sv =====
// lpfd_checker: scoreboard for the length-prefixed frame deframer
// follows config writes and both byte channels, predicts each result and compares it
// depends on lpfd_pkg
module lpfd_checker import lpfd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgLenW-1:0]     cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [ByteW-1:0]       rx_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [ByteW-1:0]       out_byte_i,
  input  logic [1:0]             kind_i,
  input  logic signed [LenW-1:0] frame_length_i,
  output int                     mismatches_o,
  output int                     pending_o,
  output int                     payloads_o,
  output int                     accepts_o,
  output int                     drops_o,
  output int                     rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    FrmLenLo,
    FrmLenHi,
    FrmPayload,
    FrmTrailer,
    FrmHunt
  } frm_state_e;

  frm_state_e         frm_state;
  logic [ByteW-1:0]   len_lo_q;
  logic [LenW-1:0]    frame_len_q;
  logic [CfgLenW-1:0] byte_cnt_q;
  cfg_t               cfg_q;
  res_t               awaited_results[$];
  int                 mismatch_cnt;
  int                 kind_cnt[4];

  function automatic void await_result(logic [ByteW-1:0] b, kind_e k, logic [LenW-1:0] len);
    res_t r;
    r.out_byte     = b;
    r.kind         = k;
    r.frame_length = len;
    awaited_results.push_back(r);
  endfunction

  function automatic void deframe_byte(logic [ByteW-1:0] b);
    logic [LenW-1:0] raw;
    int              len_val;
    int              len_top;
    case (frm_state)
      FrmLenLo: begin
        len_lo_q  = b;
        frm_state = FrmLenHi;
      end
      FrmLenHi: begin
        raw         = {b, len_lo_q};
        len_val     = int'($signed(raw));
        len_top     = (cfg_q.max_len > LengthLimit) ? int'(LengthLimit) : int'(cfg_q.max_len);
        frame_len_q = raw;
        byte_cnt_q  = '0;
        if (len_val < int'(cfg_q.min_len) || len_val > len_top) begin
          await_result('0, KindReject, raw);
          // a delimiter in the length bytes marks where the next frame starts
          if (len_lo_q == cfg_q.delim) begin
            len_lo_q = b;
          end else if (b == cfg_q.delim) begin
            frm_state = FrmLenLo;
          end else begin
            frm_state = FrmHunt;
          end
        end else begin
          frm_state = (len_val == 0) ? FrmTrailer : FrmPayload;
        end
      end
      FrmPayload: begin
        await_result(b, KindPayload, '0);
        byte_cnt_q = byte_cnt_q + 1'b1;
        if ({4'h0, byte_cnt_q} >= frame_len_q) frm_state = FrmTrailer;
      end
      FrmTrailer: begin
        if (b == cfg_q.delim) begin
          await_result('0, KindAccept, frame_len_q);
          frm_state = FrmLenLo;
        end else begin
          await_result('0, KindDrop, frame_len_q);
          frm_state = FrmHunt;
        end
      end
      default: begin
        frm_state = (b == cfg_q.delim) ? FrmLenLo : FrmHunt;
      end
    endcase
  endfunction

  function automatic void check_result();
    res_t want;
    if (awaited_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: unexpected result byte %02h kind %0d length %0d",
                 $realtime, out_byte_i, kind_i, frame_length_i);
      end
    end else begin
      want = awaited_results.pop_front();
      kind_cnt[want.kind]++;
      if (out_byte_i !== want.out_byte || kind_i !== want.kind ||
          frame_length_i !== want.frame_length) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: expected byte %02h kind %0d length %0d, got byte %02h kind %0d length %0d",
                   $realtime, want.out_byte, want.kind, want.frame_length,
                   out_byte_i, kind_i, frame_length_i);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_state    = FrmLenLo;
      len_lo_q     = '0;
      frame_len_q  = '0;
      byte_cnt_q   = '0;
      cfg_q        = '{delim: DelimRst, min_len: MinLengthRst, max_len: MaxLengthRst};
      awaited_results.delete();
      mismatch_cnt = 0;
      kind_cnt     = '{default: 0};
      mismatches_o <= 0;
      pending_o    <= 0;
      payloads_o   <= 0;
      accepts_o    <= 0;
      drops_o      <= 0;
      rejects_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) deframe_byte(rx_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDelim:  cfg_q.delim   = cfg_wdata_i[ByteW-1:0];
          CfgMinLen: cfg_q.min_len = cfg_wdata_i;
          CfgMaxLen: cfg_q.max_len = cfg_wdata_i;
          default: ;
        endcase
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= awaited_results.size();
      payloads_o   <= kind_cnt[KindPayload];
      accepts_o    <= kind_cnt[KindAccept];
      drops_o      <= kind_cnt[KindDrop];
      rejects_o    <= kind_cnt[KindReject];
    end
  end

endmodule

// ===== sim/length_prefixed_frame_deframer_tb.sv =====
// length_prefixed_frame_deframer_tb: stimulus and verdict for the frame deframer
// feeds corner and random byte streams under several length windows, lpfd_checker compares
// depends on lpfd_pkg, lpfd_checker and length_prefixed_frame_deframer
module length_prefixed_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfd_pkg::*;

  localparam int CycleLimit = 300000;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx   = '0;
  logic [CfgLenW-1:0]     cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic [ByteW-1:0]       rx_byte   = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [ByteW-1:0]       out_byte;
  logic [1:0]             kind;
  logic signed [LenW-1:0] frame_length;

  int mismatches, pending, payloads, accepts, drops, rejects;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int settings_cnt = 0;
  bit calm         = 1'b0;

  logic [ByteW-1:0]   cur_delim = DelimRst;
  logic [CfgLenW-1:0] cur_min   = MinLengthRst;
  logic [CfgLenW-1:0] cur_max   = MaxLengthRst;

  length_prefixed_frame_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .kind_o         (kind),
    .frame_length_o (frame_length)
  );

  lpfd_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_i     (out_byte),
    .kind_i         (kind),
    .frame_length_i (frame_length),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .payloads_o     (payloads),
    .accepts_o      (accepts),
    .drops_o        (drops),
    .rejects_o      (rejects)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("TB_ERROR");
    $finish;
  end

  // calm stretches run without any idle cycles
  function automatic int draw_wait();
    if ($urandom_range(0, 63) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic int len_limit();
    return (cur_max > LengthLimit) ? int'(LengthLimit) : int'(cur_max);
  endfunction

  function automatic bit len_ok(logic [LenW-1:0] raw);
    int v;
    v = int'($signed(raw));
    return v >= int'(cur_min) && v <= len_limit();
  endfunction

  function automatic logic [ByteW-1:0] other_byte();
    logic [ByteW-1:0] r;
    r = ByteW'($urandom);
    if (r == cur_delim) r = r ^ 8'h01;
    return r;
  endfunction

  function automatic logic [ByteW-1:0] other_neg();
    logic [ByteW-1:0] r;
    r = other_byte() | 8'h80;
    if (r == cur_delim) r = r ^ 8'h01;
    return r;
  endfunction

  function automatic int pick_len();
    int lim, span, r;
    lim  = len_limit();
    span = lim - int'(cur_min);
    r    = $urandom_range(0, 255);
    if (r == 0) return $urandom_range(int'(cur_min), lim);
    if (r < 16) return int'(cur_min);
    if (r < 32 && span <= 64) return lim;
    return int'(cur_min) + $urandom_range(0, (span < 12) ? span : 12);
  endfunction

  initial begin : rx_side
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [ByteW-1:0] d, input logic [CfgLenW-1:0] mn,
                           input logic [CfgLenW-1:0] mx, input bit poke_unused);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgDelim;
    cfg_wdata <= {{(CfgLenW-ByteW){1'b0}}, d};
    @(posedge clk_i);
    cfg_idx   <= CfgMinLen;
    cfg_wdata <= mn;
    @(posedge clk_i);
    cfg_idx   <= CfgMaxLen;
    cfg_wdata <= mx;
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx   <= CfgUnused;
      cfg_wdata <= CfgLenW'($urandom);
      @(posedge clk_i);
    end
    cfg_we    <= 1'b0;
    cur_delim = d;
    cur_min   = mn;
    cur_max   = mx;
    settings_cnt++;
  endtask

  task automatic hunt_bytes(input int n);
    repeat (n) send_byte(other_byte());
    send_byte(cur_delim);
  endtask

  task automatic send_frame(input int len, input bit good_end);
    logic [LenW-1:0] raw;
    raw = LenW'(len);
    send_byte(raw[7:0]);
    send_byte(raw[15:8]);
    for (int i = 0; i < len; i++) begin
      send_byte(($urandom_range(0, 7) == 0) ? cur_delim : ByteW'($urandom));
    end
    if (good_end) begin
      send_byte(cur_delim);
    end else begin
      send_byte(other_byte());
      hunt_bytes($urandom_range(0, 3));
    end
  endtask

  task automatic send_bad_length();
    logic [ByteW-1:0] lo, hi;
    logic [LenW-1:0]  bound_len;
    int               pick;
    pick = $urandom_range(0, 3);
    lo   = other_byte();
    bound_len = (cur_min > 0 && $urandom_range(0, 1) == 1) ? LenW'(cur_min - 1)
                                                            : LenW'(len_limit() + 1);
    if (pick == 1 && !len_ok({cur_delim, lo})) begin
      send_byte(lo);
      send_byte(cur_delim);
    end else if (pick == 2) begin
      // delimiter first: the high byte becomes the next low byte, both negative
      hi = other_neg();
      send_byte(cur_delim);
      send_byte(hi);
      send_byte(other_neg());
      hunt_bytes($urandom_range(0, 3));
    end else begin
      if (pick == 3 && !len_ok(bound_len) && bound_len[7:0] != cur_delim &&
          bound_len[15:8] != cur_delim) begin
        lo = bound_len[7:0];
        hi = bound_len[15:8];
      end else begin
        hi = other_byte();
        if (len_ok({hi, lo})) hi = other_neg();
      end
      send_byte(lo);
      send_byte(hi);
      hunt_bytes($urandom_range(0, 3));
    end
  endtask

  task automatic run_phase(input int budget);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      if (len_limit() >= int'(cur_min) && $urandom_range(0, 99) < 65) begin
        send_frame(pick_len(), $urandom_range(0, 6) != 0);
      end else begin
        send_bad_length();
      end
    end
    settle();
  endtask

  initial begin : stimulus
    logic [ByteW-1:0]   corner_a[$] = '{8'h00, 8'h00, 8'h7E,
                                        8'h02, 8'h00, 8'hFF, 8'h7E, 8'h7E,
                                        8'h01, 8'h00, 8'h00, 8'h55, 8'h7E,
                                        8'h00, 8'h80, 8'h7E,
                                        8'h7E, 8'h00, 8'h00, 8'h7E,
                                        8'hFF, 8'h7E};
    logic [ByteW-1:0]   corner_b[$] = '{8'h01, 8'h08, 8'h00, 8'hFF, 8'h7F, 8'h00};
    logic [CfgLenW-1:0] win_lo, win_hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(8'h7E, 12'd0, 12'd8, 1'b0);
    foreach (corner_a[i]) send_byte(corner_a[i]);
    settle();
    write_cfg(8'h00, 12'd0, 12'hFFF, 1'b1);
    foreach (corner_b[i]) send_byte(corner_b[i]);
    settle();

    write_cfg(DelimRst, MinLengthRst, MaxLengthRst, 1'b0);
    run_phase(100);
    write_cfg(8'hFF, 12'd0, 12'hFFF, 1'b0);
    run_phase(80);
    write_cfg(ByteW'($urandom), 12'd50, 12'd10, 1'b0);
    run_phase(50);
    write_cfg(ByteW'($urandom), 12'd0, 12'd0, 1'b0);
    run_phase(50);
    write_cfg(ByteW'($urandom), CfgLenW'(LengthLimit), CfgLenW'(LengthLimit), 1'b1);
    send_frame(int'(LengthLimit), 1'b1);
    send_bad_length();
    settle();
    for (int k = 0; k < 3; k++) begin
      win_lo = CfgLenW'($urandom_range(0, 40));
      win_hi = ($urandom_range(0, 9) == 0) ? CfgLenW'($urandom_range(0, 4095))
                                           : win_lo + CfgLenW'($urandom_range(0, 30));
      write_cfg(ByteW'($urandom), win_lo, win_hi, 1'b0);
      run_phase(50);
    end

    $display("deframer run: %0d bytes sent under %0d register settings", bytes_sent,
             settings_cnt);
    $display("results seen: %0d payload bytes, %0d accepted, %0d dropped, %0d rejected lengths",
             payloads, accepts, drops, rejects);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
